// File: hdl/lss_pkg.sv
// Shared types and constants of the lookahead subgoal selector.
package lss_pkg;

   localparam int MAX_WAYPOINTS = 256;
   localparam int IDX_W = $clog2(MAX_WAYPOINTS);
   localparam int LEN_W = IDX_W + 1;

   localparam int COORD_W = 24;
   localparam int TOL_W = 23;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int PATH_WORD_W = 2 * COORD_W;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_TOL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HORIZON = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBGOAL_TOL = 2'd2;

   localparam logic [TOL_W-1:0] GOAL_TOL_RESET = 23'd128;
   localparam logic [TOL_W-1:0] HORIZON_RESET = 23'd1280;
   localparam logic [TOL_W-1:0] SUBGOAL_TOL_RESET = 23'd128;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_CLEAR = 3'd1;
   localparam logic [2:0] CMD_GOAL = 3'd2;
   localparam logic [2:0] CMD_ROBOT = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;

   localparam logic [2:0] ST_FOUND = 3'd0;
   localparam logic [2:0] ST_GOAL_REACHED = 3'd1;
   localparam logic [2:0] ST_NONE = 3'd2;
   localparam logic [2:0] ST_NO_GOAL = 3'd3;
   localparam logic [2:0] ST_ACCEPTED = 3'd4;
   localparam logic [2:0] ST_PATH_FULL = 3'd5;

   typedef struct packed {
      logic [2:0] command;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic subgoal_reached;
      logic signed [COORD_W-1:0] subgoal_x;
      logic signed [COORD_W-1:0] subgoal_y;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
   } dist_req_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic busy;
      logic [DIST_W-1:0] d;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
   } dist_rsp_type;

endpackage

// File: hdl/lss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/lss_dist.sv
// Three-stage pipelined squared-distance unit carrying the second point along.
module lss_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  lss_pkg::dist_req_type req,
   output lss_pkg::dist_rsp_type rsp
);
   import lss_pkg::*;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff;
   logic [DIFF_W-1:0] abs_x_ff, abs_y_ff;
   logic [SQ_W-1:0] sq_x_ff, sq_y_ff;
   logic [DIST_W-1:0] d_ff;
   logic signed [COORD_W-1:0] s1_bx_ff, s1_by_ff, s2_bx_ff, s2_by_ff, s3_bx_ff, s3_by_ff;

   logic signed [DIFF_W-1:0] dx_in, dy_in;
   logic [DIFF_W-1:0] abs_x_in, abs_y_in;

   always_comb begin
      dx_in = {req.a_x[COORD_W-1], req.a_x} - {req.b_x[COORD_W-1], req.b_x};
      dy_in = {req.a_y[COORD_W-1], req.a_y} - {req.b_y[COORD_W-1], req.b_y};
      abs_x_in = dx_in[DIFF_W-1] ? DIFF_W'(-dx_in) : DIFF_W'(dx_in);
      abs_y_in = dy_in[DIFF_W-1] ? DIFF_W'(-dy_in) : DIFF_W'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_last_ff <= req.last;
      s2_last_ff <= s1_last_ff;
      s3_last_ff <= s2_last_ff;
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      sq_x_ff <= abs_x_ff * abs_x_ff;
      sq_y_ff <= abs_y_ff * abs_y_ff;
      d_ff <= {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      s1_bx_ff <= req.b_x;
      s1_by_ff <= req.b_y;
      s2_bx_ff <= s1_bx_ff;
      s2_by_ff <= s1_by_ff;
      s3_bx_ff <= s2_bx_ff;
      s3_by_ff <= s2_by_ff;
   end

   always_comb begin
      rsp.valid = s3_valid_ff;
      rsp.last = s3_last_ff;
      rsp.busy = s1_valid_ff | s2_valid_ff | s3_valid_ff;
      rsp.d = d_ff;
      rsp.b_x = s3_bx_ff;
      rsp.b_y = s3_by_ff;
   end

endmodule

// File: hdl/lookahead_subgoal_selector.sv
// Top level of the lookahead subgoal selector: command sequencer, path RAM, output register.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   req_word_type (command, pos_x, pos_y)
//   rsp      out        rsp_valid/rsp_stall   rsp_word_type (status, reached, subgoal)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// Append, clear, set goal and plain position updates go straight to the response state; a
// position update with a subgoal set checks it first, and a reach re-runs the query. A query
// settles on goal reach or goal within horizon from the goal distance; else a path scan reads
// one waypoint per cycle into the three-stage distance pipeline.
// Reset is synchronous; the path RAM is not cleared, the path length len_ff starts at zero.
// A new word is taken while a finished result waits under rsp_stall.
module lookahead_subgoal_selector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lss_pkg::req_word_type       req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lss_pkg::rsp_word_type       rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lss_pkg::TOL_W-1:0]   csr_data
);
   import lss_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_CHK_ISSUE  = 8'b0000_0010,
      S_CHK_WAIT   = 8'b0000_0100,
      S_GOAL_ISSUE = 8'b0000_1000,
      S_GOAL_WAIT  = 8'b0001_0000,
      S_SCAN       = 8'b0010_0000,
      S_DRAIN      = 8'b0100_0000,
      S_RESP       = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [TOL_W-1:0] goal_tol_ff, horizon_ff, sub_tol_ff;
   logic [TOL_W:0] hi_sum_ff;
   logic [TOL_W-1:0] lo_diff_ff;
   logic has_lo_ff, has_lo_sq_ff;
   logic [2*TOL_W-1:0] gt2_ff, hor2_ff, st2_ff, lo2_ff;
   logic [2*TOL_W+1:0] hi2_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic scan_issue_ff, scan_issue_in;
   logic rd_valid_ff, rd_last_ff;
   logic signed [COORD_W-1:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic signed [COORD_W-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [COORD_W-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic goal_valid_ff, goal_valid_in;
   logic [2:0] status_ff, status_in;
   logic reached_ff, reached_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic ram_wr_en, ram_rd_en, rd_last_in;
   logic [PATH_WORD_W-1:0] ram_rd_data;
   dist_req_type dist_req;
   dist_rsp_type dist_rsp;
   logic hit;

   lss_ram #(
      .WIDTH(PATH_WORD_W),
      .DEPTH(MAX_WAYPOINTS)
   ) u_path (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(len_ff[IDX_W-1:0]),
      .wr_data({req_word.pos_x, req_word.pos_y}),
      .rd_en(ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   lss_dist u_dist (
      .clock(clock),
      .reset(reset),
      .req(dist_req),
      .rsp(dist_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_tol_ff <= GOAL_TOL_RESET;
         horizon_ff <= HORIZON_RESET;
         sub_tol_ff <= SUBGOAL_TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GOAL_TOL: goal_tol_ff <= csr_data;
            CSR_HORIZON: horizon_ff <= csr_data;
            CSR_SUBGOAL_TOL: sub_tol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // threshold squares, registered; the band squares pass a sum or difference register first
   always_ff @(posedge clock) begin
      hi_sum_ff <= {1'b0, horizon_ff} + {1'b0, sub_tol_ff};
      has_lo_ff <= (horizon_ff >= sub_tol_ff);
      lo_diff_ff <= horizon_ff - sub_tol_ff;
      gt2_ff <= goal_tol_ff * goal_tol_ff;
      hor2_ff <= horizon_ff * horizon_ff;
      st2_ff <= sub_tol_ff * sub_tol_ff;
      hi2_ff <= hi_sum_ff * hi_sum_ff;
      lo2_ff <= lo_diff_ff * lo_diff_ff;
      has_lo_sq_ff <= has_lo_ff;
   end

   assign hit = (dist_rsp.d < DIST_W'(hi2_ff)) &&
                (!has_lo_sq_ff || dist_rsp.d > DIST_W'(lo2_ff));

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      scan_issue_in = scan_issue_ff;
      robot_x_in = robot_x_ff;
      robot_y_in = robot_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      goal_valid_in = goal_valid_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      status_in = status_ff;
      reached_in = reached_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      rd_last_in = 1'b0;
      dist_req = '0;
      dist_req.a_x = robot_x_ff;
      dist_req.a_y = robot_y_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               reached_in = 1'b0;
               status_in = ST_ACCEPTED;
               state_in = S_RESP;
               case (req_word.command)
                  CMD_APPEND: begin
                     if (len_ff < LEN_W'(MAX_WAYPOINTS)) begin
                        ram_wr_en = 1'b1;
                        len_in = len_ff + 1'b1;
                     end else begin
                        status_in = ST_PATH_FULL;
                     end
                  end
                  CMD_CLEAR: len_in = '0;
                  CMD_GOAL: begin
                     goal_x_in = req_word.pos_x;
                     goal_y_in = req_word.pos_y;
                     goal_valid_in = 1'b1;
                  end
                  CMD_ROBOT: begin
                     robot_x_in = req_word.pos_x;
                     robot_y_in = req_word.pos_y;
                     if (goal_valid_ff && (target_x_ff != '0 || target_y_ff != '0) &&
                         (target_x_ff != goal_x_ff || target_y_ff != goal_y_ff)) begin
                        state_in = S_CHK_ISSUE;
                     end
                  end
                  CMD_QUERY: begin
                     if (goal_valid_ff) begin
                        state_in = S_GOAL_ISSUE;
                     end else begin
                        status_in = ST_NO_GOAL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHK_ISSUE: begin
            dist_req.valid = 1'b1;
            dist_req.last = 1'b1;
            dist_req.b_x = target_x_ff;
            dist_req.b_y = target_y_ff;
            state_in = S_CHK_WAIT;
         end
         S_CHK_WAIT: begin
            if (dist_rsp.valid) begin
               if (dist_rsp.d <= DIST_W'(st2_ff)) begin
                  reached_in = 1'b1;
                  state_in = S_GOAL_ISSUE;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_GOAL_ISSUE: begin
            dist_req.valid = 1'b1;
            dist_req.last = 1'b1;
            dist_req.b_x = goal_x_ff;
            dist_req.b_y = goal_y_ff;
            state_in = S_GOAL_WAIT;
         end
         S_GOAL_WAIT: begin
            if (dist_rsp.valid) begin
               if (dist_rsp.d <= DIST_W'(gt2_ff)) begin
                  status_in = ST_GOAL_REACHED;
                  state_in = S_RESP;
               end else if (dist_rsp.d < DIST_W'(hor2_ff)) begin
                  target_x_in = goal_x_ff;
                  target_y_in = goal_y_ff;
                  status_in = ST_FOUND;
                  state_in = S_RESP;
               end else if (len_ff == '0) begin
                  status_in = ST_NONE;
                  state_in = S_RESP;
               end else begin
                  idx_in = '0;
                  scan_issue_in = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_issue_ff) begin
               ram_rd_en = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_W'(len_ff - 1'b1)) begin
                  rd_last_in = 1'b1;
                  scan_issue_in = 1'b0;
               end
            end
            if (dist_rsp.valid) begin
               if (hit) begin
                  target_x_in = dist_rsp.b_x;
                  target_y_in = dist_rsp.b_y;
                  status_in = ST_FOUND;
                  scan_issue_in = 1'b0;
                  state_in = S_DRAIN;
               end else if (dist_rsp.last) begin
                  status_in = ST_NONE;
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!dist_rsp.busy && !rd_valid_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.status = status_ff;
               rsp_word_in.subgoal_reached = reached_ff;
               rsp_word_in.subgoal_x = target_x_ff;
               rsp_word_in.subgoal_y = target_y_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // waypoint read data enters the distance pipeline
      if (rd_valid_ff) begin
         dist_req.valid = 1'b1;
         dist_req.last = rd_last_ff;
         dist_req.b_x = ram_rd_data[PATH_WORD_W-1:COORD_W];
         dist_req.b_y = ram_rd_data[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         scan_issue_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         robot_x_ff <= '0;
         robot_y_ff <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         goal_valid_ff <= 1'b0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         scan_issue_ff <= scan_issue_in;
         rd_valid_ff <= ram_rd_en;
         robot_x_ff <= robot_x_in;
         robot_y_ff <= robot_y_in;
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         goal_valid_ff <= goal_valid_in;
         target_x_ff <= target_x_in;
         target_y_ff <= target_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      rd_last_ff <= rd_last_in;
      status_ff <= status_in;
      reached_ff <= reached_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the lookahead subgoal selector.
`timescale 1ns / 1ps

module testbench;
   import lss_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 500;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 250;
   localparam logic [2:0] CMD_UNUSED_A = 3'd5;
   localparam logic [2:0] CMD_UNUSED_B = 3'd6;
   localparam logic [2:0] CMD_UNUSED_C = 3'd7;
   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;

   class subgoal_tracker;
      logic signed [COORD_W-1:0] path_x [MAX_WAYPOINTS];
      logic signed [COORD_W-1:0] path_y [MAX_WAYPOINTS];
      int unsigned path_len;
      logic signed [COORD_W-1:0] robot_x, robot_y, goal_x, goal_y, target_x, target_y;
      bit goal_set;
      longint unsigned goal_tol, horizon, sub_tol;
      rsp_word_type awaited [$];
      int unsigned mismatches, checked, reach_count;
      int unsigned status_count [8];

      function new();
         path_len = 0;
         robot_x = '0;
         robot_y = '0;
         goal_x = '0;
         goal_y = '0;
         target_x = '0;
         target_y = '0;
         goal_set = 1'b0;
         goal_tol = GOAL_TOL_RESET;
         horizon = HORIZON_RESET;
         sub_tol = SUBGOAL_TOL_RESET;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [TOL_W-1:0] data);
         case (index)
            CSR_GOAL_TOL: goal_tol = data;
            CSR_HORIZON: horizon = data;
            CSR_SUBGOAL_TOL: sub_tol = data;
            default: ;
         endcase
      endfunction

      function longint unsigned dist_sq(logic signed [COORD_W-1:0] ax,
                                        logic signed [COORD_W-1:0] ay,
                                        logic signed [COORD_W-1:0] bx,
                                        logic signed [COORD_W-1:0] by);
         longint dx, dy;
         dx = longint'(ax) - longint'(bx);
         dy = longint'(ay) - longint'(by);
         return longint'(dx * dx + dy * dy);
      endfunction

      // goal reach, goal inside horizon, else first waypoint inside the band
      function logic [2:0] pick_subgoal();
         longint unsigned dg, hi, lo, d;
         bit has_lo;
         int unsigned i;
         dg = dist_sq(robot_x, robot_y, goal_x, goal_y);
         if (dg <= goal_tol * goal_tol) return ST_GOAL_REACHED;
         if (dg < horizon * horizon) begin
            target_x = goal_x;
            target_y = goal_y;
            return ST_FOUND;
         end
         hi = (horizon + sub_tol) * (horizon + sub_tol);
         has_lo = horizon >= sub_tol;
         lo = has_lo ? (horizon - sub_tol) * (horizon - sub_tol) : 0;
         for (i = 0; i < path_len; i++) begin
            d = dist_sq(robot_x, robot_y, path_x[i], path_y[i]);
            if (d < hi && (!has_lo || d > lo)) begin
               target_x = path_x[i];
               target_y = path_y[i];
               return ST_FOUND;
            end
         end
         return ST_NONE;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type e;
         e.status = ST_ACCEPTED;
         e.subgoal_reached = 1'b0;
         case (w.command)
            CMD_APPEND: begin
               if (path_len < MAX_WAYPOINTS) begin
                  path_x[path_len] = w.pos_x;
                  path_y[path_len] = w.pos_y;
                  path_len++;
               end else begin
                  e.status = ST_PATH_FULL;
               end
            end
            CMD_CLEAR: path_len = 0;
            CMD_GOAL: begin
               goal_x = w.pos_x;
               goal_y = w.pos_y;
               goal_set = 1'b1;
            end
            CMD_ROBOT: begin
               robot_x = w.pos_x;
               robot_y = w.pos_y;
               if (goal_set && (target_x != 0 || target_y != 0) &&
                   dist_sq(robot_x, robot_y, target_x, target_y) <= sub_tol * sub_tol &&
                   (target_x != goal_x || target_y != goal_y)) begin
                  e.subgoal_reached = 1'b1;
                  e.status = pick_subgoal();
               end
            end
            CMD_QUERY: e.status = goal_set ? pick_subgoal() : ST_NO_GOAL;
            default: ;
         endcase
         e.subgoal_x = target_x;
         e.subgoal_y = target_y;
         status_count[e.status]++;
         reach_count += e.subgoal_reached;
         awaited = {awaited, e};
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report(string what);
         if (mismatches < 100) $display("MISMATCH at result %0d: %s", checked, what);
         mismatches++;
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (awaited.size() == 0) begin
            report("result word arrived with none awaited");
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.subgoal_reached !== want.subgoal_reached)
            report($sformatf("subgoal_reached %0b, expected %0b",
                             got.subgoal_reached, want.subgoal_reached));
         if (got.subgoal_x !== want.subgoal_x)
            report($sformatf("subgoal_x %0d, expected %0d", got.subgoal_x, want.subgoal_x));
         if (got.subgoal_y !== want.subgoal_y)
            report($sformatf("subgoal_y %0d, expected %0d", got.subgoal_y, want.subgoal_y));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TOL_W-1:0] csr_data = '0;

   subgoal_tracker sb;
   bit quiet = 1'b0;
   bit hold_output = 1'b0;
   int unsigned words_sent = 0;
   int unsigned settings_written = 0;
   int unsigned cycle_count = 0;

   lookahead_subgoal_selector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lookahead_subgoal_selector verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_word);
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 9);
         end
      end
   end

   function automatic int spread(int a);
      if (a <= 0) return 0;
      return int'($urandom_range(2 * a)) - a;
   endfunction

   function automatic req_word_type make_word(logic [2:0] cmd, int x, int y);
      req_word_type w;
      w.command = cmd;
      w.pos_x = x[COORD_W-1:0];
      w.pos_y = y[COORD_W-1:0];
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(int gt, int ph, int st);
      logic [CSR_INDEX_W-1:0] idx [3];
      int vals [3];
      int i;
      idx = '{CSR_GOAL_TOL, CSR_HORIZON, CSR_SUBGOAL_TOL};
      vals = '{gt, ph, st};
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i][TOL_W-1:0];
         do @(posedge clock); while (!csr_ready);
         sb.write_register(idx[i], vals[i][TOL_W-1:0]);
      end
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   task automatic run_directed();
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_ROBOT, 0, 0));
      send_word(make_word(CMD_UNUSED_A, COORD_MAX, COORD_MAX));
      send_word(make_word(CMD_UNUSED_B, COORD_MIN, COORD_MIN));
      send_word(make_word(CMD_UNUSED_C, 0, -1));
      send_word(make_word(CMD_GOAL, COORD_MAX, COORD_MAX));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_APPEND, COORD_MAX, COORD_MIN));
      send_word(make_word(CMD_APPEND, COORD_MIN, COORD_MAX));
      send_word(make_word(CMD_APPEND, 1280, 0));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_ROBOT, 1280, 100));
      send_word(make_word(CMD_CLEAR, 123, -456));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_GOAL, 1000, 100));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_ROBOT, 1050, 100));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_GOAL, COORD_MIN, COORD_MIN));
      send_word(make_word(CMD_APPEND, 0, 0));
      send_word(make_word(CMD_ROBOT, 1280, 0));
      send_word(make_word(CMD_QUERY, 0, 0));
      send_word(make_word(CMD_ROBOT, 10, 0));
   endtask

   // clear, usually goal, start, waypoints partly toward the goal, query, then drive, mostly toward subgoals
   task automatic run_mission(int n_points, bit fill_path);
      int dir_x [8];
      int dir_y [8];
      int rx, ry, gx, gy, h, t, gt, scale, k, i, r, d, steps, pick, x, y;
      dir_x = '{5, 0, -5, 0, 3, -3, 4, -4};
      dir_y = '{0, 5, 0, -5, 4, 4, -3, -3};
      h = int'(sb.horizon);
      t = int'(sb.sub_tol);
      gt = int'(sb.goal_tol);
      scale = (h < 32) ? 32 : ((h > (1 << 20)) ? (1 << 20) : h);
      rx = spread(1 << 21);
      ry = spread(1 << 21);
      gx = rx + spread(8 * scale);
      gy = ry + spread(8 * scale);
      send_word(make_word(CMD_CLEAR, $urandom(), $urandom()));
      if ($urandom_range(9) != 0) send_word(make_word(CMD_GOAL, gx, gy));
      send_word(make_word(CMD_ROBOT, rx, ry));
      k = fill_path ? MAX_WAYPOINTS + 2 : n_points;
      for (i = 1; i <= k; i++) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            x = rx + (gx - rx) / k * i + spread(scale / 8);
            y = ry + (gy - ry) / k * i + spread(scale / 8);
         end else if (pick < 8) begin
            d = $urandom_range(7);
            r = h + spread(t);
            x = rx + r * dir_x[d] / 5;
            y = ry + r * dir_y[d] / 5;
         end else begin
            case ($urandom_range(3))
               0: begin x = rx + h + t; y = ry; end
               1: begin x = rx + h - t; y = ry; end
               2: begin x = rx; y = ry - h; end
               default: begin x = rx; y = ry; end
            endcase
         end
         send_word(make_word(CMD_APPEND, x, y));
      end
      send_word(make_word(CMD_QUERY, 0, 0));
      steps = $urandom_range(3, 10);
      for (i = 0; i < steps; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            x = int'(sb.target_x) + spread(t / 2);
            y = int'(sb.target_y) + spread(t / 2);
            send_word(make_word(CMD_ROBOT, x, y));
         end else if (pick < 75) begin
            x = int'(sb.robot_x) + spread(scale);
            y = int'(sb.robot_y) + spread(scale);
            send_word(make_word(CMD_ROBOT, x, y));
         end else if (pick < 90) begin
            send_word(make_word(CMD_QUERY, $urandom(), $urandom()));
         end else begin
            send_word(make_word(3'($urandom_range(7)), $urandom(), $urandom()));
         end
      end
      if ($urandom_range(1)) begin
         if ($urandom_range(1)) x = int'(sb.goal_x) + gt;
         else x = int'(sb.goal_x) + spread(gt / 2);
         send_word(make_word(CMD_ROBOT, x, int'(sb.goal_y)));
         send_word(make_word(CMD_QUERY, 0, 0));
      end
   endtask

   initial begin
      int gt_set [PHASES];
      int ph_set [PHASES];
      int st_set [PHASES];
      int p, n;
      int unsigned phase_start;
      gt_set = '{128, 0, 8388607, 40, 300, 64, 0, 0};
      ph_set = '{1280, 0, 8388607, 1000, 200, 4096, 8388607, 0};
      st_set = '{128, 0, 8388607, 1000, 500, 32, 0, 0};
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain_results();
      gt_set[PHASES-1] = $urandom_range(1000);
      ph_set[PHASES-1] = $urandom_range(20000);
      st_set[PHASES-1] = $urandom_range(2000);
      for (p = 0; p < PHASES; p++) begin
         configure(gt_set[p], ph_set[p], st_set[p]);
         if (p == 5) hold_output = 1'b1;
         quiet = (p == PHASES - 1);
         phase_start = words_sent;
         if (p == 0 || p == 5) run_mission(0, 1'b1);
         while (words_sent - phase_start < PHASE_WORDS) begin
            case ($urandom_range(9))
               0: n = 0;
               1: n = $urandom_range(13, 40);
               default: n = $urandom_range(1, 12);
            endcase
            run_mission(n, 1'b0);
         end
         drain_results();
      end
      quiet = 1'b0;
      repeat (300) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d result words never arrived", sb.pending()));
      $display("covered %0d request words, %0d results, %0d register settings",
               words_sent, sb.checked, settings_written + 1);
      $display("found %0d, goal reached %0d, none %0d, no goal %0d, path full %0d, reach %0d",
               sb.status_count[ST_FOUND], sb.status_count[ST_GOAL_REACHED],
               sb.status_count[ST_NONE], sb.status_count[ST_NO_GOAL],
               sb.status_count[ST_PATH_FULL], sb.reach_count);
      if (sb.mismatches == 0) begin
         $display("lookahead_subgoal_selector verification clean");
      end else begin
         $display("lookahead_subgoal_selector verification failed");
      end
      $finish;
   end
endmodule
